FILE: design/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types, constants and the digit decoder of the integer string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

	// data path widths
	localparam int ACC_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int CHAR_WIDTH  = 8;
	localparam int BASE_WIDTH  = 5;
	localparam int DIGIT_WIDTH = 4;

	// configuration port
	localparam int ADDR_WIDTH = 3;
	localparam int DATA_WIDTH = 32;
	localparam logic [ADDR_WIDTH-1:0] ADDR_FORCED_BASE = 3'd0;
	localparam logic [ADDR_WIDTH-1:0] ADDR_SIGNED_MODE = 3'd4;

	// register reset values
	localparam logic [BASE_WIDTH-1:0] FORCED_BASE_RESET = 5'd0;
	localparam logic                  SIGNED_MODE_RESET = 1'b1;

	// bases
	localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 5'd0;
	localparam logic [BASE_WIDTH-1:0] BASE_BIN  = 5'd2;
	localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 5'd8;
	localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 5'd10;
	localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 5'd16;

	// characters
	localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_1     = 8'h31;
	localparam logic [CHAR_WIDTH-1:0] CH_7     = 8'h37;
	localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_WIDTH-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_WIDTH-1:0] CH_UB    = 8'h42;
	localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_WIDTH-1:0] CH_LB    = 8'h62;
	localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_WIDTH-1:0] CASE_MASK = 8'hdf;

	// parse phase within one string
	typedef enum logic [2:0] {
		PH_START,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_STOPPED
	} phase_t;

	// configuration seen by the parser
	typedef struct packed {
		logic [BASE_WIDTH-1:0] forced_base;
		logic                  signed_mode;
	} cfg_t;

	// digit decode result
	typedef struct packed {
		logic                   valid;
		logic [DIGIT_WIDTH-1:0] value;
	} digit_t;

	// value of character c as a digit of base b
	function automatic digit_t digit_of(input logic [CHAR_WIDTH-1:0] c,
			input logic [BASE_WIDTH-1:0] b);
		digit_t                d;
		logic                  is_dec;
		logic                  is_alpha;
		logic [CHAR_WIDTH-1:0] up;
		logic [CHAR_WIDTH-1:0] dv;
		logic [CHAR_WIDTH-1:0] av;
		is_dec   = (c >= CH_0) && (c <= CH_9);
		is_alpha = ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
		up       = c & CASE_MASK;
		dv       = c - CH_0;
		av       = up - CH_UA + 8'd10;
		d.valid  = 1'b0;
		d.value  = dv[DIGIT_WIDTH-1:0];
		case (b)
			BASE_BIN: d.valid = (c >= CH_0) && (c <= CH_1);
			BASE_OCT: d.valid = (c >= CH_0) && (c <= CH_7);
			BASE_DEC: d.valid = is_dec;
			BASE_HEX: begin
				d.valid = is_dec || is_alpha;
				if (!is_dec) begin
					d.value = av[DIGIT_WIDTH-1:0];
				end
			end
			default: d.valid = 1'b0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: design/isp_cfg.sv
// ----------------------------------------------------------------------------
// isp_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_cfg
	import isp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_WIDTH-1:0] paddr,
	input  wire logic [DATA_WIDTH-1:0] pwdata,
	output logic      [DATA_WIDTH-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [BASE_WIDTH-1:0] forced_base_q;
	logic                  signed_mode_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forced_base_q <= FORCED_BASE_RESET;
			signed_mode_q <= SIGNED_MODE_RESET;
		end else if (wr_en) begin
			if (paddr == ADDR_FORCED_BASE) begin
				forced_base_q <= pwdata[BASE_WIDTH-1:0];
			end
			if (paddr == ADDR_SIGNED_MODE) begin
				signed_mode_q <= pwdata[0];
			end
		end
	end

	// read back
	always_comb begin
		case (paddr)
			ADDR_FORCED_BASE: prdata = {{(DATA_WIDTH-BASE_WIDTH){1'b0}}, forced_base_q};
			ADDR_SIGNED_MODE: prdata = {{(DATA_WIDTH-1){1'b0}}, signed_mode_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.forced_base = forced_base_q;
	assign cfg.signed_mode = signed_mode_q;

endmodule

`default_nettype wire

FILE: design/isp_core.sv
// ----------------------------------------------------------------------------
// isp_core
// Per-string parse state and the one-character update step.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_core
	import isp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [CHAR_WIDTH-1:0]  char_s1,
	input  wire cfg_t                   cfg,
	output logic      [VALUE_WIDTH-1:0] result
);

	phase_t                phase_q, phase_d;
	logic [BASE_WIDTH-1:0] base_q, base_d;
	logic [ACC_WIDTH-1:0]  acc_q, acc_d;
	logic                  neg_q, neg_d;

	logic                  do_take;
	logic [BASE_WIDTH-1:0] take_base;
	digit_t                dig;
	logic [ACC_WIDTH-1:0]  acc_scaled;
	logic [ACC_WIDTH-1:0]  acc_neg;
	logic                  is_end;

	assign is_end = (char_s1 == CH_NUL);

	// choose the base for this character and whether it is taken as a digit
	always_comb begin
		phase_d   = phase_q;
		base_d    = base_q;
		neg_d     = neg_q;
		do_take   = 1'b0;
		take_base = base_q;
		case (phase_q)
			PH_START, PH_SIGNED: begin
				if ((phase_q == PH_START) && cfg.signed_mode && (char_s1 == CH_MINUS)) begin
					neg_d   = 1'b1;
					phase_d = PH_SIGNED;
				end else if (cfg.forced_base != BASE_AUTO) begin
					take_base = cfg.forced_base;
					do_take   = 1'b1;
				end else if (char_s1 == CH_0) begin
					phase_d = PH_ZERO;
				end else begin
					take_base = BASE_DEC;
					do_take   = 1'b1;
				end
			end
			PH_ZERO: begin
				if ((char_s1 == CH_LB) || (char_s1 == CH_UB)) begin
					base_d  = BASE_BIN;
					phase_d = PH_DIGITS;
				end else if ((char_s1 == CH_LX) || (char_s1 == CH_UX)) begin
					base_d  = BASE_HEX;
					phase_d = PH_DIGITS;
				end else begin
					take_base = BASE_OCT;
					do_take   = 1'b1;
				end
			end
			PH_DIGITS: do_take = 1'b1;
			default:   phase_d = PH_STOPPED;
		endcase
		if (do_take) begin
			base_d  = take_base;
			phase_d = dig.valid ? PH_DIGITS : PH_STOPPED;
		end
	end

	// digit decode and shift-add multiply by the base
	always_comb begin
		dig = digit_of(char_s1, take_base);
		case (take_base)
			BASE_BIN: acc_scaled = acc_q << 1;
			BASE_OCT: acc_scaled = acc_q << 3;
			BASE_DEC: acc_scaled = (acc_q << 3) + (acc_q << 1);
			BASE_HEX: acc_scaled = acc_q << 4;
			default:  acc_scaled = acc_q;
		endcase
		if (do_take && dig.valid) begin
			acc_d = acc_scaled + {{(ACC_WIDTH-DIGIT_WIDTH){1'b0}}, dig.value};
		end else begin
			acc_d = acc_q;
		end
	end

	// result for the string ending now
	assign acc_neg = '0 - acc_q;
	assign result  = neg_q ? acc_neg[VALUE_WIDTH-1:0] : acc_q[VALUE_WIDTH-1:0];

	// state registers, cleared at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			base_q  <= BASE_DEC;
			acc_q   <= '0;
			neg_q   <= 1'b0;
		end else if (step) begin
			if (is_end) begin
				phase_q <= PH_START;
				base_q  <= BASE_DEC;
				acc_q   <= '0;
				neg_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				base_q  <= base_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/integer_string_parser.sv
// ----------------------------------------------------------------------------
// integer_string_parser
// C-style integer string parser, one character byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, char_in) carries one character per
//   item; a NUL byte ends the string. Output channel (out_valid, out_stall,
//   value) carries one 32-bit result per string, produced by the NUL item.
//   Non-NUL items produce no output.
//   A NUL passes the input register and, once the output register is free,
//   its result is loaded into the output register and shows on value.
//   Throughput: one character per cycle, set by the single input register
//   and the one-step shift-add update of the accumulator, but for a stalled NUL.
//   When the receiver stalls, the result holds in the output register and
//   characters keep flowing; only a NUL meeting a full, stalled output
//   register stalls the input, and then in_stall follows out_stall.
//   Reset (arst_n low) clears the parse state and both registers: the block
//   starts at the beginning of a string, forced_base 0, signed_mode 1.
//   Registers: forced_base at byte address 0, signed_mode at 4; write only
//   while no string is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_string_parser
	import isp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [CHAR_WIDTH-1:0]  char_in,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [VALUE_WIDTH-1:0] value,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_WIDTH-1:0]  paddr,
	input  wire logic [DATA_WIDTH-1:0]  pwdata,
	output logic      [DATA_WIDTH-1:0]  prdata,
	output logic                        pready
);

	cfg_t                   cfg;
	logic                   valid_s1;
	logic [CHAR_WIDTH-1:0]  char_s1;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [VALUE_WIDTH-1:0] result;
	logic                   out_free;
	logic                   s1_fire;
	logic                   in_accept;

	isp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	isp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_fire),
		.char_s1 (char_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// flow control: only a NUL needs room in the output register
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_fire   = valid_s1 && ((char_s1 != CH_NUL) || out_free);
	assign in_stall  = valid_s1 && !s1_fire;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= char_in;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && (char_s1 == CH_NUL)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && (char_s1 == CH_NUL)) begin
			value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

`default_nettype wire

FILE: design/isp_checker.sv
// ----------------------------------------------------------------------------
// isp_checker
// Port-level checks of the integer string parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_checker
	import isp_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic [CHAR_WIDTH-1:0]  char_in,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [VALUE_WIDTH-1:0] value
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value))
		else $error("stalled result changed or dropped");

	// input backs up only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room at the output");

	// an accepted end of string is followed by a result
	a_nul_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (char_in == CH_NUL) |-> ##2 out_valid)
		else $error("end of string gave no result");

endmodule

bind integer_string_parser isp_checker u_isp_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: integer_string_parser testbench
// Streams character items through the parser under random sender bursts and
// receiver stalls, predicts every parsed value and checks each result item.
// ----------------------------------------------------------------------------

module tb;
	import isp_pkg::*;

	localparam int RESET_CYCLES   = 9;
	localparam int HOLD_CYCLES    = 4;
	localparam int END_CYCLES     = 10;
	localparam int QUIET_LIMIT    = 4000;
	localparam int ITEMS_PER_SET  = 107;
	localparam int FIXED_SETS     = 10;
	localparam int RANDOM_SETS    = 4;
	localparam int PRINT_LIMIT    = 40;

	// clock, reset and block inputs
	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   in_valid = 1'b0;
	logic [CHAR_WIDTH-1:0]  char_in  = '0;
	logic                   out_stall = 1'b0;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [ADDR_WIDTH-1:0]  paddr    = '0;
	logic [DATA_WIDTH-1:0]  pwdata   = '0;

	// block outputs
	wire                    in_stall;
	wire                    out_valid;
	wire [VALUE_WIDTH-1:0]  value;
	wire [DATA_WIDTH-1:0]   prdata;
	wire                    pready;

	integer_string_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #2 clk = ~clk;

	// pending character items and predicted parse values
	logic [CHAR_WIDTH-1:0]  pending_chars[$];
	logic [VALUE_WIDTH-1:0] expected_values[$];

	// parser shadow state and register copies
	phase_t                 scan_phase    = PH_START;
	logic [BASE_WIDTH-1:0]  scan_base     = BASE_DEC;
	logic [ACC_WIDTH-1:0]   scan_acc      = '0;
	logic                   scan_negative = 1'b0;
	logic [BASE_WIDTH-1:0]  cfg_forced_base = FORCED_BASE_RESET;
	logic                   cfg_signed_mode = SIGNED_MODE_RESET;

	int  error_count  = 0;
	int  quiet_cycles = 0;
	int  counted_items = 0;
	logic in_acc  = 1'b0;
	logic out_acc = 1'b0;

	// sender burst and receiver stall pattern state
	int burst_left = 1;
	int gap_left   = 0;
	int stall_pct  = 0;
	int mode_left  = 0;

	// register settings for the fixed sets
	int  set_base[FIXED_SETS] = '{16, 2, 8, 10, 31, 5, 0, 1, 16, 0};
	bit  set_sign[FIXED_SETS] = '{0, 1, 1, 0, 1, 0, 0, 1, 1, 1};

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	// digit value of c in base b, -1 when not a digit
	function automatic int digit_in_base(input logic [CHAR_WIDTH-1:0] c,
			input logic [BASE_WIDTH-1:0] b);
		bit dec_digit;
		bit hex_letter;
		dec_digit  = (c >= CH_0) && (c <= CH_9);
		hex_letter = ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
		case (b)
			BASE_BIN: return ((c >= CH_0) && (c <= CH_1)) ? int'(c - CH_0) : -1;
			BASE_OCT: return ((c >= CH_0) && (c <= CH_7)) ? int'(c - CH_0) : -1;
			BASE_DEC: return dec_digit ? int'(c - CH_0) : -1;
			BASE_HEX: begin
				if (dec_digit) begin
					return int'(c - CH_0);
				end
				return hex_letter ? int'((c & CASE_MASK) - CH_UA) + 10 : -1;
			end
			default: return -1;
		endcase
	endfunction

	// one shift-add step, or stop on a non-digit
	task automatic shift_in(input logic [CHAR_WIDTH-1:0] c);
		int d;
		d = digit_in_base(c, scan_base);
		if (d < 0) begin
			scan_phase = PH_STOPPED;
		end else begin
			scan_acc   = scan_acc * ACC_WIDTH'(scan_base) + ACC_WIDTH'(d);
			scan_phase = PH_DIGITS;
		end
	endtask

	// advance the shadow parser by one accepted character
	task automatic parse_char(input logic [CHAR_WIDTH-1:0] c);
		logic [VALUE_WIDTH-1:0] result;
		if (c == CH_NUL) begin
			result = scan_negative ? VALUE_WIDTH'(0) - scan_acc : scan_acc;
			expected_values.push_back(result);
			scan_phase    = PH_START;
			scan_base     = BASE_DEC;
			scan_acc      = '0;
			scan_negative = 1'b0;
		end else begin
			case (scan_phase)
				PH_START, PH_SIGNED: begin
					if (scan_phase == PH_START && cfg_signed_mode && c == CH_MINUS) begin
						scan_negative = 1'b1;
						scan_phase    = PH_SIGNED;
					end else if (cfg_forced_base != BASE_AUTO) begin
						scan_base = cfg_forced_base;
						shift_in(c);
					end else if (c == CH_0) begin
						scan_phase = PH_ZERO;
					end else begin
						scan_base = BASE_DEC;
						shift_in(c);
					end
				end
				PH_ZERO: begin
					if (c == CH_LB || c == CH_UB) begin
						scan_base  = BASE_BIN;
						scan_phase = PH_DIGITS;
					end else if (c == CH_LX || c == CH_UX) begin
						scan_base  = BASE_HEX;
						scan_phase = PH_DIGITS;
					end else begin
						scan_base = BASE_OCT;
						shift_in(c);
					end
				end
				PH_DIGITS: shift_in(c);
				default: scan_phase = PH_STOPPED;
			endcase
		end
	endtask

	// acceptance, prediction, result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_acc  = in_valid && !in_stall;
			out_acc = out_valid && !out_stall;
			if (in_acc) begin
				parse_char(char_in);
			end
			if (out_acc) begin
				if (expected_values.size() == 0) begin
					report_mismatch($sformatf("result %h with no string pending", value));
				end else if (value !== expected_values[0]) begin
					report_mismatch($sformatf("value got %h expected %h",
						value, expected_values[0]));
					void'(expected_values.pop_front());
				end else begin
					void'(expected_values.pop_front());
				end
			end
			if (in_acc || out_acc || (psel && penable)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// sender: bursts of items with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_acc)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_chars.size() > 0) begin
				char_in  <= pending_chars.pop_front();
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: gap_left = 0;
						9:          gap_left = $urandom_range(13, 30);
						default:    gap_left = $urandom_range(1, 12);
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, with a stall density that is redrawn at random intervals
	always @(negedge clk) begin
		if (mode_left == 0) begin
			mode_left = $urandom_range(32, 256);
			case ($urandom_range(0, 3))
				0:       stall_pct = 0;
				1:       stall_pct = 25;
				2:       stall_pct = 60;
				default: stall_pct = 90;
			endcase
		end
		mode_left--;
		out_stall <= int'($urandom_range(0, 99)) < stall_pct;
	end

	task automatic apb_access(input logic write_en, input logic [ADDR_WIDTH-1:0] addr,
			input logic [DATA_WIDTH-1:0] data, output logic [DATA_WIDTH-1:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write_en;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// program both registers and read them back
	task automatic program_config(input logic [BASE_WIDTH-1:0] fb, input logic sm);
		logic [DATA_WIDTH-1:0] rd;
		apb_access(1'b1, ADDR_FORCED_BASE, DATA_WIDTH'(fb), rd);
		cfg_forced_base = fb;
		apb_access(1'b1, ADDR_SIGNED_MODE, DATA_WIDTH'(sm), rd);
		cfg_signed_mode = sm;
		apb_access(1'b0, ADDR_FORCED_BASE, '0, rd);
		if (rd !== DATA_WIDTH'(fb)) begin
			report_mismatch($sformatf("forced_base read %h expected %h", rd, fb));
		end
		apb_access(1'b0, ADDR_SIGNED_MODE, '0, rd);
		if (rd !== DATA_WIDTH'(sm)) begin
			report_mismatch($sformatf("signed_mode read %h expected %h", rd, sm));
		end
	endtask

	// wait until every item is taken and every value has come out
	task automatic wait_drained();
		@(negedge clk);
		while (pending_chars.size() != 0 || in_valid || expected_values.size() != 0) begin
			@(negedge clk);
		end
		repeat (HOLD_CYCLES) @(negedge clk);
	endtask

	task automatic add_char(input logic [CHAR_WIDTH-1:0] c, input bit counts);
		pending_chars.push_back(c);
		if (counts) begin
			counted_items++;
		end
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i], 1'b1);
		end
		add_char(CH_NUL, 1'b1);
	endtask

	function automatic logic [CHAR_WIDTH-1:0] digit_char(input int b);
		int d;
		d = $urandom_range(0, b - 1);
		if (d < 10) begin
			return CH_0 + CHAR_WIDTH'(d);
		end
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + CHAR_WIDTH'(d - 10);
	endfunction

	// one random string: mostly well-formed numbers, some noise and junk
	task automatic add_random_string();
		int b;
		int ndig;
		int njunk;
		if ($urandom_range(0, 99) < 10) begin
			ndig = $urandom_range(1, 8);
			for (int i = 0; i < ndig; i++) begin
				add_char(CHAR_WIDTH'($urandom_range(1, 255)), 1'b1);
			end
		end else begin
			if ($urandom_range(0, 99) < 40) begin
				add_char(CH_MINUS, 1'b1);
			end
			if (cfg_forced_base inside {BASE_BIN, BASE_OCT, BASE_DEC, BASE_HEX} &&
					$urandom_range(0, 99) < 75) begin
				b = int'(cfg_forced_base);
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						b = 2;
						add_char(CH_0, 1'b1);
						add_char($urandom_range(0, 1) ? CH_LB : CH_UB, 1'b1);
					end
					1: begin
						b = 8;
						add_char(CH_0, 1'b1);
					end
					2: b = 10;
					default: begin
						b = 16;
						add_char(CH_0, 1'b1);
						add_char($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b1);
					end
				endcase
			end
			// occasional long strings to wrap the accumulator
			ndig = ($urandom_range(0, 99) < 10) ? $urandom_range(15, 40) : $urandom_range(0, 10);
			for (int i = 0; i < ndig; i++) begin
				add_char(digit_char(b), 1'b1);
			end
			if ($urandom_range(0, 99) < 20) begin
				add_char(CHAR_WIDTH'($urandom_range(1, 255)), 1'b1);
				njunk = $urandom_range(0, 4);
				for (int i = 0; i < njunk; i++) begin
					add_char(CHAR_WIDTH'($urandom_range(1, 255)), 1'b0);
				end
			end
		end
		add_char(CH_NUL, 1'b1);
	endtask

	// reset, directed strings, then sets of random strings per setting
	initial begin
		int target;
		logic [BASE_WIDTH-1:0] fb;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lone prefixes, sign, invalid digit, extreme bytes, minus mid-string
		add_text("");
		add_text("0");
		add_text("0X");
		add_text("0b");
		add_text("-7z9");
		add_text("0xfF");
		add_char(8'hff, 1'b1);
		add_char(CH_0 + 8'd5, 1'b1);
		add_char(CH_NUL, 1'b1);
		add_text("12-3");

		target = counted_items;
		for (int s = 0; s < FIXED_SETS + RANDOM_SETS; s++) begin
			wait_drained();
			if (s < FIXED_SETS) begin
				program_config(BASE_WIDTH'(set_base[s]), set_sign[s]);
			end else begin
				case ($urandom_range(0, 5))
					0:       fb = BASE_AUTO;
					1:       fb = BASE_BIN;
					2:       fb = BASE_OCT;
					3:       fb = BASE_DEC;
					4:       fb = BASE_HEX;
					default: fb = BASE_WIDTH'($urandom_range(0, 31));
				endcase
				program_config(fb, 1'($urandom_range(0, 1)));
			end
			target += ITEMS_PER_SET;
			while (counted_items < target) begin
				add_random_string();
			end
		end

		wait_drained();
		repeat (END_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
